FILE: rtl/metaball_field_shader_unit_macros.svh
// Assertion macros shared by the metaball field shader RTL.
// Needs aclk and aresetn in the scope of every module that uses them.
`ifndef METABALL_FIELD_SHADER_UNIT_MACROS_SVH
`define METABALL_FIELD_SHADER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define MFS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define MFS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MFS_ASSERT_IMP(name, ante, cons, msg)
`define MFS_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

FILE: rtl/mfs_pkg.sv
// Types and fixed-point widths for the metaball field shader.
// No dependencies; used by mfs_cell and metaball_field_shader_unit.
package mfs_pkg;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SHADE = 1'b1
    } op_t;

    localparam int SLOT_W    = 3;
    localparam int CENTER_W  = 13;  // signed Q4 pixels
    localparam int INV_W     = 16;  // unsigned Q0.20
    localparam int PIX_W     = 7;
    localparam int Q4_BITS   = 4;
    localparam int DIFF_W    = 14;  // signed Q4 distance
    localparam int SQ_W      = 26;  // one squared distance, Q8, for any 13-bit centre
    localparam int D2_W      = 27;  // sum of both squares, Q8
    localparam int PROD_W    = 43;  // d2 * inverse radius, Q28
    localparam int K_FRAC    = 28;
    localparam int K_W       = 29;  // 1 - product, Q28, up to exactly one
    localparam int KSQ_W     = 57;  // k squared, Q56, up to exactly one
    localparam int FIELD_FRAC = 56;
    localparam int INDEX_W   = 8;

    localparam logic [K_W-1:0] K_ONE = K_W'(1) << K_FRAC;

    typedef struct packed {
        op_t                        op;
        logic [SLOT_W-1:0]          slot;
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic [INV_W-1:0]           inv;
        logic [PIX_W-1:0]           pixel_x;
        logic [PIX_W-1:0]           pixel_y;
    } item_t;

endpackage

FILE: rtl/mfs_cell.sv
// One ball of the shading chain: holds the ball and adds its share to each pixel.
// Depends on mfs_pkg and metaball_field_shader_unit_macros.svh.
`include "metaball_field_shader_unit_macros.svh"

module mfs_cell #(
    parameter int INDEX   = 0,
    parameter int FIELD_W = 60
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 in_valid,
    input  mfs_pkg::item_t       in_item,
    input  logic [FIELD_W-1:0]   in_field,
    output logic                 out_valid,
    output mfs_pkg::item_t       out_item,
    output logic [FIELD_W-1:0]   out_field
);
    import mfs_pkg::*;

    // Ball held by this cell.
    logic signed [CENTER_W-1:0] cx_reg;
    logic signed [CENTER_W-1:0] cy_reg;
    logic [INV_W-1:0]           inv_reg;
    logic                       loaded_reg;

    // Four internal stages.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    item_t s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;
    logic [FIELD_W-1:0] s1_field_reg, s2_field_reg, s3_field_reg, s4_field_reg;
    logic s1_hit_reg, s2_hit_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [INV_W-1:0]  s1_inv_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [KSQ_W-1:0]  ksq_reg;

    logic                       write_hit;
    logic signed [DIFF_W-1:0]   px_q4, py_q4, dx, dy;
    logic signed [2*DIFF_W-1:0] dx_sq, dy_sq;
    logic [D2_W-1:0]            d2;
    logic [PROD_W-1:0]          prod_next;
    logic                       in_range;
    logic [K_W-1:0]             k;
    logic [KSQ_W-1:0]           ksq_full;
    logic [KSQ_W-1:0]           ksq_next;
    logic [FIELD_W-1:0]         field_next;

    assign write_hit = in_valid && (in_item.op == OP_LOAD) && (int'(in_item.slot) == INDEX);

    assign px_q4 = {3'b000, in_item.pixel_x, 4'b0000};
    assign py_q4 = {3'b000, in_item.pixel_y, 4'b0000};
    assign dx    = px_q4 - DIFF_W'(cx_reg);
    assign dy    = py_q4 - DIFF_W'(cy_reg);
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    assign d2        = D2_W'(sqx_reg) + D2_W'(sqy_reg);
    assign prod_next = d2 * s1_inv_reg;

    // k contributes only while the product stays below one.
    assign in_range = (prod_reg[PROD_W-1:K_FRAC] == '0);
    assign k        = K_ONE - K_W'(prod_reg[K_FRAC-1:0]);
    assign ksq_full = k * k;
    assign ksq_next = (s2_hit_reg && in_range) ? ksq_full : '0;

    assign field_next = s3_field_reg + FIELD_W'(ksq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (advance) begin
            if (write_hit) begin
                loaded_reg <= 1'b1;
            end
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (write_hit) begin
                cx_reg  <= in_item.center_x;
                cy_reg  <= in_item.center_y;
                inv_reg <= in_item.inv;
            end
            s1_item_reg  <= in_item;
            s1_field_reg <= in_field;
            s1_hit_reg   <= (in_item.op == OP_SHADE) && loaded_reg;
            s1_inv_reg   <= inv_reg;
            sqx_reg      <= dx_sq[SQ_W-1:0];
            sqy_reg      <= dy_sq[SQ_W-1:0];

            s2_item_reg  <= s1_item_reg;
            s2_field_reg <= s1_field_reg;
            s2_hit_reg   <= s1_hit_reg;
            prod_reg     <= prod_next;

            s3_item_reg  <= s2_item_reg;
            s3_field_reg <= s2_field_reg;
            ksq_reg      <= ksq_next;

            s4_item_reg  <= s3_item_reg;
            s4_field_reg <= field_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;
    assign out_field = s4_field_reg;

    `MFS_ASSERT_NXT(a_load_sets_flag, advance && write_hit, loaded_reg, "load did not mark ball")
    `MFS_ASSERT_NXT(a_miss_adds_nothing, advance && !s2_hit_reg, ksq_reg == '0, "unloaded ball added")
    `MFS_ASSERT_NXT(a_stall_holds, !advance, $stable(s4_valid_reg), "chain moved during stall")

endmodule

FILE: rtl/metaball_field_shader_unit.sv
// Top level of the metaball field shader: a chain of ball cells and the output stage.
// Depends on mfs_pkg, mfs_cell and metaball_field_shader_unit_macros.svh.
//
// Every item, load or pixel, enters a chain of NUM_BALLS cells, one ball per cell, and
// moves through four register stages in each: distance squares, scaling by the inverse
// radius, the squared falloff, and the running field sum. A load writes its ball as it
// passes that ball's cell, so pixels sent after a load see it and pixels sent before do
// not. One item is taken per clock while the output is free; a pixel's palette index
// is registered after the last cell, loads give no result. A result that is not taken holds the
// whole chain, so input transfers stop until it leaves. Reset clears every ball.
`include "metaball_field_shader_unit_macros.svh"

module metaball_field_shader_unit #(
    parameter int NUM_BALLS = 5
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [0:0]                           s_operation,
    input  logic [mfs_pkg::SLOT_W-1:0]           s_ball_slot,
    input  logic signed [mfs_pkg::CENTER_W-1:0]  s_ball_center_x,
    input  logic signed [mfs_pkg::CENTER_W-1:0]  s_ball_center_y,
    input  logic [mfs_pkg::INV_W-1:0]            s_ball_inverse_radius_sq,
    input  logic [mfs_pkg::PIX_W-1:0]            s_pixel_x,
    input  logic [mfs_pkg::PIX_W-1:0]            s_pixel_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mfs_pkg::INDEX_W-1:0]          m_palette_index
);
    import mfs_pkg::*;

    localparam int FIELD_W  = KSQ_W + $clog2(NUM_BALLS);
    localparam int SCALED_W = FIELD_W + 8;

    logic                 m_valid_reg;
    logic [INDEX_W-1:0]   m_palette_index_reg;

    logic                 advance;
    item_t                s_item;
    logic                 valid_chain [NUM_BALLS+1];
    item_t                item_chain  [NUM_BALLS+1];
    logic [FIELD_W-1:0]   field_chain [NUM_BALLS+1];

    logic [FIELD_W-1:0]   field_last;
    logic [SCALED_W-1:0]  field_wide;
    logic [SCALED_W-1:0]  scaled;
    logic                 saturate;
    logic [INDEX_W-1:0]   index_next;
    logic                 result_next;

    // The chain moves whenever the output register is free or being emptied.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    assign s_item.op       = op_t'(s_operation);
    assign s_item.slot     = s_ball_slot;
    assign s_item.center_x = s_ball_center_x;
    assign s_item.center_y = s_ball_center_y;
    assign s_item.inv      = s_ball_inverse_radius_sq;
    assign s_item.pixel_x  = s_pixel_x;
    assign s_item.pixel_y  = s_pixel_y;

    assign valid_chain[0] = s_valid;
    assign item_chain[0]  = s_item;
    assign field_chain[0] = '0;

    for (genvar i = 0; i < NUM_BALLS; i++) begin : g_cell
        mfs_cell #(
            .INDEX   (i),
            .FIELD_W (FIELD_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (valid_chain[i]),
            .in_item   (item_chain[i]),
            .in_field  (field_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_item  (item_chain[i+1]),
            .out_field (field_chain[i+1])
        );
    end

    // Index is floor(field * 200) with the field in Q56; 200 = 128 + 64 + 8.
    assign field_last = field_chain[NUM_BALLS];
    assign field_wide = SCALED_W'(field_last);
    assign scaled     = (field_wide << 7) + (field_wide << 6) + (field_wide << 3);
    assign saturate   = |scaled[SCALED_W-1:FIELD_FRAC+INDEX_W];
    assign index_next = saturate ? '1 : scaled[FIELD_FRAC+INDEX_W-1:FIELD_FRAC];

    assign result_next = valid_chain[NUM_BALLS] && (item_chain[NUM_BALLS].op == OP_SHADE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_palette_index_reg <= index_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_palette_index = m_palette_index_reg;

    `MFS_ASSERT_NXT(a_load_no_result, advance && valid_chain[NUM_BALLS] && !result_next,
                    !m_valid, "load produced a result")
    `MFS_ASSERT_NXT(a_held_result_stalls, m_valid && !m_ready,
                    $stable(valid_chain[NUM_BALLS]), "chain moved under held result")
    `MFS_ASSERT_NXT(a_held_index_stable, m_valid && !m_ready,
                    m_valid && $stable(m_palette_index), "held result changed")

endmodule
